>>> sv/dal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dal_pkg
// Shared constants and helpers for the double-ended array list.
// ----------------------------------------------------------------------------
package dal_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COUNT_W-1:0] t_count;

    // ring position: head plus offset, wrapped once at the capacity
    function automatic t_addr ring_add(input t_addr head, input t_addr offset);
        logic [ADDR_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (ADDR_W+1)'(CAPACITY)) begin
            sum = sum - (ADDR_W+1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> sv/dal_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dal_cmd_if / dal_res_if
// Valid/ready channels for commands into the list and results out of it.
// ----------------------------------------------------------------------------
interface dal_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [dal_pkg::CMD_W-1:0]     cmd;
    logic signed [dal_pkg::VALUE_W-1:0] value;
    logic [dal_pkg::INDEX_W-1:0]   index;

    modport source (output valid, output cmd, output value, output index, input ready);
    modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

interface dal_res_if;
    logic                          valid;
    logic                          ready;
    logic [dal_pkg::STATUS_W-1:0]  status;
    logic signed [dal_pkg::VALUE_W-1:0] data;
    logic [dal_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink   (input valid, input status, input data, input count, output ready);
endinterface

>>> sv/double_ended_array_list.sv
`timescale 1ns / 1ps
// a result is registered and appears in the cycle after its command transfer
// throughput: one command per cycle while results are taken; a stalled result holds
// off the next command until it transfers. each command makes at most one access to the element ram
// pointer and count updates happen at the command transfer, so the next command
// reads the written entry without forwarding
// reset: count and head cleared, no result pending, no command taken; element ram is not cleared
// ----------------------------------------------------------------------------
// double_ended_array_list
// Bounded double-ended list of signed words held in a ring in one RAM.
// ----------------------------------------------------------------------------
module double_ended_array_list (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dal_cmd_if.sink    i_cmd,
    dal_res_if.source  o_res
);

    dal_pkg::t_count r_count, n_count;
    dal_pkg::t_addr  r_head, n_head;

    logic                           r_s1_valid;
    logic [dal_pkg::STATUS_W-1:0]   r_s1_status, n_s1_status;
    dal_pkg::t_count                r_s1_count;
    logic                           r_s1_has_data, n_s1_has_data;

    logic                           cmd_xfer;
    logic                           wr_en;
    dal_pkg::t_addr                 wr_addr;
    logic                           rd_en;
    dal_pkg::t_addr                 rd_addr;
    logic [dal_pkg::VALUE_W-1:0]    rd_data;
    logic                           full;
    logic                           empty;
    dal_pkg::t_addr                 cnt_addr;

    // a new command enters when no result is pending or in the cycle the pending result transfers
    assign i_cmd.ready = i_rst_n && (!r_s1_valid || o_res.ready);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;

    assign full     = (r_count >= dal_pkg::COUNT_W'(dal_pkg::CAPACITY));
    assign empty    = (r_count == '0);
    assign cnt_addr = r_count[dal_pkg::ADDR_W-1:0];

    always_comb begin
        n_count       = r_count;
        n_head        = r_head;
        n_s1_status   = dal_pkg::ST_OK;
        n_s1_has_data = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = dal_pkg::ring_add(r_head, cnt_addr);
        rd_en         = 1'b0;
        rd_addr       = r_head;
        case (i_cmd.cmd)
            dal_pkg::CMD_PUSH_BACK: begin
                if (full) begin
                    n_s1_status = dal_pkg::ST_FULL;
                end else begin
                    wr_en   = cmd_xfer;
                    n_count = r_count + 1'b1;
                end
            end
            dal_pkg::CMD_PUSH_FRONT: begin
                if (full) begin
                    n_s1_status = dal_pkg::ST_FULL;
                end else begin
                    n_head  = (r_head == '0) ? dal_pkg::ADDR_W'(dal_pkg::CAPACITY - 1)
                                             : r_head - 1'b1;
                    wr_addr = n_head;
                    wr_en   = cmd_xfer;
                    n_count = r_count + 1'b1;
                end
            end
            dal_pkg::CMD_POP_BACK: begin
                if (empty) begin
                    n_s1_status = dal_pkg::ST_EMPTY;
                end else begin
                    rd_addr       = dal_pkg::ring_add(r_head, cnt_addr - 1'b1);
                    rd_en         = cmd_xfer;
                    n_s1_has_data = 1'b1;
                    n_count       = r_count - 1'b1;
                end
            end
            dal_pkg::CMD_POP_FRONT: begin
                if (empty) begin
                    n_s1_status = dal_pkg::ST_EMPTY;
                end else begin
                    rd_addr       = r_head;
                    rd_en         = cmd_xfer;
                    n_s1_has_data = 1'b1;
                    n_head        = dal_pkg::ring_add(r_head, dal_pkg::ADDR_W'(1));
                    n_count       = r_count - 1'b1;
                end
            end
            dal_pkg::CMD_READ: begin
                if (dal_pkg::COUNT_W'(i_cmd.index) >= r_count) begin
                    n_s1_status = dal_pkg::ST_RANGE;
                end else begin
                    rd_addr       = dal_pkg::ring_add(r_head,
                                        dal_pkg::ADDR_W'(i_cmd.index));
                    rd_en         = cmd_xfer;
                    n_s1_has_data = 1'b1;
                end
            end
            default: begin
                // unused codes leave count and head as they are and still return an ok result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_head     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (cmd_xfer) begin
                r_count    <= n_count;
                r_head     <= n_head;
                r_s1_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_s1_status   <= n_s1_status;
            r_s1_count    <= n_count;
            r_s1_has_data <= n_s1_has_data;
        end
    end

    dal_ram #(
        .WIDTH (dal_pkg::VALUE_W),
        .DEPTH (dal_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ram output holds while stalled since reads only fire on a command transfer
    assign o_res.valid  = r_s1_valid;
    assign o_res.status = r_s1_status;
    assign o_res.data   = r_s1_has_data ? rd_data : '0;
    assign o_res.count  = r_s1_count;

endmodule

>>> sv/dal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
